// ===== design/ibsbp_pkg.sv =====
// Shared types and constants for the IR blob sort and beacon pick block.
// No dependencies; every other design file refers to this package.
package ibsbp_pkg;

  localparam int NUM_CAMERAS = 2;
  localparam int MAX_BLOBS   = 4;
  localparam int CAM_W       = 1;
  localparam int CNT_W       = $clog2(MAX_BLOBS + 1);
  localparam int COORD_W     = 10;
  localparam int BYTE_W      = 8;
  localparam int SPREAD_W    = 14;
  localparam int STATUS_W    = 2;
  localparam int REG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0]   X_HIGH_BITS = 8'h30;
  localparam logic [BYTE_W-1:0]   Y_HIGH_BITS = 8'hC0;
  localparam int                  X_HI_LSB    = 4;
  localparam int                  Y_HI_LSB    = 6;
  localparam int                  HI_W        = COORD_W - BYTE_W;
  localparam logic [BYTE_W-1:0]   EMPTY_SLOT  = 8'd255;
  localparam logic [SPREAD_W-1:0] SINGLE_MARK = 14'd9999;

  localparam logic [COORD_W-1:0] Y_LOWER_RESET  = 10'd0;
  localparam logic [COORD_W-1:0] Y_UPPER_RESET  = 10'd1023;
  localparam logic [COORD_W-1:0] PAIR_TOL_RESET = 10'd16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_Y_LOWER  = 2'd0,
    REG_Y_UPPER  = 2'd1,
    REG_PAIR_TOL = 2'd2
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    PICK_NONE   = 2'd0,
    PICK_SINGLE = 2'd1,
    PICK_PAIR   = 2'd2,
    PICK_NOPAIR = 2'd3
  } pick_status_t;

  typedef struct packed {
    logic [CAM_W-1:0]   cam;
    logic               keep;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_rd_t;

endpackage

// ===== design/ibsbp_if.sv =====
// Channel interfaces: blob records in, pick results out, register writes.
// Depends on ibsbp_pkg.
interface ibsbp_in_if;
  logic                           valid;
  logic                           ready;
  logic [ibsbp_pkg::CAM_W-1:0]    camera_sel;
  logic [ibsbp_pkg::BYTE_W-1:0]   x_low_byte;
  logic [ibsbp_pkg::BYTE_W-1:0]   y_low_byte;
  logic [ibsbp_pkg::BYTE_W-1:0]   high_bits_byte;
  logic                           slot_last;
  modport source (output valid, camera_sel, x_low_byte, y_low_byte, high_bits_byte,
                  slot_last, input ready);
  modport sink (input valid, camera_sel, x_low_byte, y_low_byte, high_bits_byte,
                slot_last, output ready);
endinterface

interface ibsbp_out_if;
  logic                            valid;
  logic                            ready;
  logic [ibsbp_pkg::STATUS_W-1:0]  pick_status;
  logic [ibsbp_pkg::CNT_W-1:0]     blob_count;
  logic [ibsbp_pkg::COORD_W-1:0]   beacon_x;
  logic [ibsbp_pkg::SPREAD_W-1:0]  pair_spread;
  modport source (output valid, pick_status, blob_count, beacon_x, pair_spread,
                  input ready);
  modport sink (input valid, pick_status, blob_count, beacon_x, pair_spread,
                output ready);
endinterface

interface ibsbp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ibsbp_pkg::REG_IDX_W-1:0]  index;
  logic [ibsbp_pkg::COORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/ibsbp_front.sv =====
// Front end: register file, record decode and Y window classification.
// Depends on ibsbp_pkg and ibsbp_if; feeds ibsbp_queue.
module ibsbp_front (
  input  logic                            clk,
  input  logic                            rst,
  ibsbp_in_if.sink                        records,
  ibsbp_cfg_if.sink                       cfg,
  input  logic                            q_full,
  output ibsbp_pkg::q_wr_t                q_wr,
  output logic [ibsbp_pkg::COORD_W-1:0]   pair_tol
);

  logic [ibsbp_pkg::COORD_W-1:0] y_lower_bound;
  logic [ibsbp_pkg::COORD_W-1:0] y_upper_bound;
  logic [ibsbp_pkg::COORD_W-1:0] pair_height_tolerance;
  logic [ibsbp_pkg::COORD_W-1:0] dec_x;
  logic [ibsbp_pkg::COORD_W-1:0] dec_y;
  logic                          in_window;
  logic                          cam_ok;
  logic                          accept;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_lower_bound         <= ibsbp_pkg::Y_LOWER_RESET;
      y_upper_bound         <= ibsbp_pkg::Y_UPPER_RESET;
      pair_height_tolerance <= ibsbp_pkg::PAIR_TOL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ibsbp_pkg::REG_Y_LOWER:  y_lower_bound         <= cfg.data;
        ibsbp_pkg::REG_Y_UPPER:  y_upper_bound         <= cfg.data;
        ibsbp_pkg::REG_PAIR_TOL: pair_height_tolerance <= cfg.data;
        default: ;
      endcase
    end
  end

  assign pair_tol = pair_height_tolerance;

  assign dec_x = {records.high_bits_byte[ibsbp_pkg::X_HI_LSB +: ibsbp_pkg::HI_W],
                  records.x_low_byte};
  assign dec_y = {records.high_bits_byte[ibsbp_pkg::Y_HI_LSB +: ibsbp_pkg::HI_W],
                  records.y_low_byte};

  assign in_window = (records.y_low_byte != ibsbp_pkg::EMPTY_SLOT) &&
                     (dec_y > y_lower_bound) && (dec_y < y_upper_bound);
  assign cam_ok = ({1'b0, records.camera_sel} <
                   (ibsbp_pkg::CAM_W + 1)'(ibsbp_pkg::NUM_CAMERAS));

  assign records.ready = !q_full;
  assign accept        = records.valid && !q_full;

  // records that neither insert nor trigger a pick are dropped here
  always_comb begin
    q_wr.push       = accept && cam_ok && (in_window || records.slot_last);
    q_wr.entry.cam  = records.camera_sel;
    q_wr.entry.keep = in_window;
    q_wr.entry.last = records.slot_last;
    q_wr.entry.x    = dec_x;
    q_wr.entry.y    = dec_y;
  end

endmodule

// ===== design/ibsbp_queue.sv =====
// Short request queue between the classifier and the list engine.
// Depends on ibsbp_pkg.
module ibsbp_queue (
  input  logic              clk,
  input  logic              rst,
  input  ibsbp_pkg::q_wr_t  q_wr,
  output logic              q_full,
  output ibsbp_pkg::q_rd_t  q_rd,
  input  logic              pop
);

  ibsbp_pkg::entry_t                slots [ibsbp_pkg::QUEUE_DEPTH];
  logic [ibsbp_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ibsbp_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ibsbp_pkg::QCNT_W-1:0]     fill;
  logic                             do_push;
  logic                             do_pop;

  assign q_full     = (fill == ibsbp_pkg::QCNT_W'(ibsbp_pkg::QUEUE_DEPTH));
  assign q_rd.valid = (fill != '0);
  assign q_rd.entry = slots[rd_ptr];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ibsbp_pkg::QPTR_W'(ibsbp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ibsbp_pkg::QPTR_W'(ibsbp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== design/ibsbp_back.sv =====
// List engine: sorted per-camera insert, adjacent pair pick, result register.
// Depends on ibsbp_pkg and ibsbp_if; fed by ibsbp_queue.
module ibsbp_back (
  input  logic                           clk,
  input  logic                           rst,
  input  ibsbp_pkg::q_rd_t               q_rd,
  output logic                           pop,
  input  logic [ibsbp_pkg::COORD_W-1:0]  pair_tol,
  ibsbp_out_if.source                    picks
);

  localparam int NB = ibsbp_pkg::MAX_BLOBS;
  localparam int CW = ibsbp_pkg::COORD_W;
  localparam int NW = ibsbp_pkg::CNT_W;

  logic [CW-1:0]                   list_x [ibsbp_pkg::NUM_CAMERAS][NB];
  logic [CW-1:0]                   list_y [ibsbp_pkg::NUM_CAMERAS][NB];
  logic [NW-1:0]                   kept_count [ibsbp_pkg::NUM_CAMERAS];
  logic [ibsbp_pkg::SPREAD_W-1:0]  spread [ibsbp_pkg::NUM_CAMERAS];

  logic                            out_valid;
  ibsbp_pkg::pick_status_t         out_status;
  logic [NW-1:0]                   out_count;
  logic [CW-1:0]                   out_beacon;
  logic [ibsbp_pkg::SPREAD_W-1:0]  out_spread;

  ibsbp_pkg::entry_t               e;
  logic [NW-1:0]                   n_old;
  logic [NW-1:0]                   n_new;
  logic                            ins;
  logic [NB-1:0]                   gt;
  logic [CW-1:0]                   new_x [NB];
  logic [CW-1:0]                   new_y [NB];
  logic [CW+1:0]                   dy;
  logic                            found;
  logic [CW-1:0]                   xa;
  logic [CW-1:0]                   xb;
  logic [CW:0]                     x_sum;
  ibsbp_pkg::pick_status_t         status_next;
  logic [CW-1:0]                   beacon_next;
  logic [ibsbp_pkg::SPREAD_W-1:0]  spread_next;

  assign e     = q_rd.entry;
  assign n_old = kept_count[e.cam];
  assign pop   = q_rd.valid && (!e.last || !out_valid || picks.ready);
  assign ins   = e.keep && (n_old < NW'(NB));
  assign n_new = ins ? n_old + 1'b1 : n_old;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      gt[i] = (NW'(i) < n_old) && (e.x < list_x[e.cam][i]);
    end
    new_x[0] = (!ins || gt[0]) ? list_x[e.cam][0] : e.x;
    new_y[0] = (!ins || gt[0]) ? list_y[e.cam][0] : e.y;
    for (int i = 1; i < NB; i++) begin
      if (!ins || gt[i]) begin
        new_x[i] = list_x[e.cam][i];
        new_y[i] = list_y[e.cam][i];
      end else if (gt[i-1]) begin
        new_x[i] = e.x;
        new_y[i] = e.y;
      end else begin
        new_x[i] = list_x[e.cam][i-1];
        new_y[i] = list_y[e.cam][i-1];
      end
    end
  end

  // first matching adjacent pair wins: scan from the tail so the head overrides
  always_comb begin
    found = 1'b0;
    xa    = '0;
    xb    = '0;
    dy    = '0;
    for (int k = NB - 2; k >= 0; k--) begin
      dy = {2'b00, new_y[k]} - {2'b00, new_y[k+1]};
      if ((NW'(k + 1) < n_new) && ($signed(dy) < $signed({2'b00, pair_tol}))) begin
        found = 1'b1;
        xa    = new_x[k];
        xb    = new_x[k+1];
      end
    end
  end

  assign x_sum = {1'b0, xa} + {1'b0, xb};

  always_comb begin
    beacon_next = '0;
    spread_next = spread[e.cam];
    if (n_new == '0) begin
      status_next = ibsbp_pkg::PICK_NONE;
    end else if (n_new == NW'(1)) begin
      status_next = ibsbp_pkg::PICK_SINGLE;
      spread_next = ibsbp_pkg::SINGLE_MARK;
    end else if (found) begin
      status_next = ibsbp_pkg::PICK_PAIR;
      beacon_next = x_sum[CW:1];
      spread_next = ibsbp_pkg::SPREAD_W'(xa - xb);
    end else begin
      status_next = ibsbp_pkg::PICK_NOPAIR;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < NB; i++) begin
        list_x[e.cam][i] <= new_x[i];
        list_y[e.cam][i] <= new_y[i];
      end
    end
    if (pop && e.last) begin
      out_status <= status_next;
      out_count  <= n_new;
      out_beacon <= beacon_next;
      out_spread <= spread_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int c = 0; c < ibsbp_pkg::NUM_CAMERAS; c++) begin
        kept_count[c] <= '0;
        spread[c]     <= '0;
      end
    end else begin
      if (pop && e.last) begin
        out_valid <= 1'b1;
      end else if (picks.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        kept_count[e.cam] <= e.last ? '0 : n_new;
        if (e.last) begin
          spread[e.cam] <= spread_next;
        end
      end
    end
  end

  assign picks.valid       = out_valid;
  assign picks.pick_status = out_status;
  assign picks.blob_count  = out_count;
  assign picks.beacon_x    = out_beacon;
  assign picks.pair_spread = out_spread;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_rd.valid |-> kept_count[e.cam] <= NW'(NB))
    else $error("blob list count above capacity");

  a_clear_after_pick: assert property (@(posedge clk) disable iff (rst)
    (pop && e.last) |=> kept_count[$past(e.cam)] == '0)
    else $error("blob list not cleared after pick");

  a_beacon_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ibsbp_pkg::PICK_PAIR) |-> out_beacon == '0)
    else $error("beacon_x nonzero without a pair");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_count == '0) |-> out_status == ibsbp_pkg::PICK_NONE)
    else $error("status wrong for empty report");

  a_insert_no_result: assert property (@(posedge clk) disable iff (rst)
    (pop && !e.last && !out_valid) |=> !out_valid)
    else $error("result raised by a plain insert");

endmodule

// ===== design/ir_blob_sort_and_beacon_pick.sv =====
// Top level of the IR blob sort and beacon pick block.
// Depends on ibsbp_pkg, ibsbp_if, ibsbp_front, ibsbp_queue and ibsbp_back.
//
//  channel   dir  handshake      payload
//  records   in   valid/ready    camera_sel, x/y low bytes, high_bits_byte, slot_last
//  picks     out  valid/ready    pick_status, blob_count, beacon_x, pair_spread
//  cfg       in   valid/ready    index, data (ready tied high)
//
// One record per cycle sustained while the queue has room. Classification is
// combinational: a request enters the two-entry queue at its accepting edge and
// the list engine takes it from the queue head, so a result reaches the output
// register when its last-slot record is popped; earlier requests ahead of it delay that.
// Synchronous reset clears counts, spreads, queue pointers and the result valid flag.
// A held result blocks the next last-slot request at the queue head; inserts
// ahead of it keep draining, and the input stalls once the queue is full.
module ir_blob_sort_and_beacon_pick (
  input  logic        clk,
  input  logic        rst,
  ibsbp_in_if.sink    records,
  ibsbp_out_if.source picks,
  ibsbp_cfg_if.sink   cfg
);

  ibsbp_pkg::q_wr_t              q_wr;
  ibsbp_pkg::q_rd_t              q_rd;
  logic                          q_full;
  logic                          pop;
  logic [ibsbp_pkg::COORD_W-1:0] pair_tol;

  ibsbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .records  (records),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .pair_tol (pair_tol)
  );

  ibsbp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .pop    (pop)
  );

  ibsbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rd     (q_rd),
    .pop      (pop),
    .pair_tol (pair_tol),
    .picks    (picks)
  );

endmodule
